// ----- rtl/tccs_pkg.sv -----
// Shared types and constants for the text cell color store.
package tccs_pkg;

	localparam int unsigned ROW_COUNT  = 64;
	localparam int unsigned COL_COUNT  = 128;
	localparam int unsigned CELL_TOTAL = ROW_COUNT * COL_COUNT;
	localparam int unsigned IDX_W      = $clog2(CELL_TOTAL);
	localparam int unsigned CNT_W      = IDX_W + 1;

	typedef enum logic [2:0] {
		OP_READ   = 3'd0,
		OP_WCHAR  = 3'd1,
		OP_WATTR  = 3'd2,
		OP_WCOLOR = 3'd3,
		OP_WCELL  = 3'd4,
		OP_FILL   = 3'd5,
		OP_MOVE   = 3'd6,
		OP_INVERT = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RMW,
		ST_RUN_RD,
		ST_RUN_WR,
		ST_OUT
	} state_t;

	// Datapath commands from the controller.
	typedef struct packed {
		logic load;     // capture the accepted item
		logic rd;       // read the cell at the current read address
		logic wr;       // write the current cell
		logic step;     // advance run addresses and count
		logic res_load; // load the result register
	} cmd_t;

	// Datapath status for the controller.
	typedef struct packed {
		op_t  op;
		logic single;   // opcode touches one cell
		logic run_zero; // run has nothing left to do
		logic run_last; // current step is the last one
	} sts_t;

endpackage

// ----- rtl/tccs_datapath.sv -----
// Cell memories, run address counters and result register.
module tccs_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  tccs_pkg::cmd_t  cmd,
	output tccs_pkg::sts_t  sts,
	input  logic [2:0]      in_op,
	input  logic [12:0]     in_dst,
	input  logic [12:0]     in_src,
	input  logic [13:0]     in_cnt,
	input  logic [7:0]      in_char,
	input  logic [7:0]      in_attr,
	input  logic [5:0]      in_fg,
	input  logic [5:0]      in_bg,
	output logic [27:0]     res
);

	localparam int unsigned IW = tccs_pkg::IDX_W;
	localparam int unsigned CW = tccs_pkg::CNT_W;

	logic [15:0] text_mem [tccs_pkg::CELL_TOTAL];
	logic [11:0] color_mem [tccs_pkg::CELL_TOTAL];

	tccs_pkg::op_t op_q;
	logic [IW-1:0] dst_q, src_q;
	logic [CW-1:0] cnt_q;
	logic          desc_q;
	logic [7:0]    char_q, attr_q;
	logic [11:0]   col_q;
	logic [15:0]   rtext_q;
	logic [11:0]   rcol_q;
	logic [27:0]   res_q;

	logic [IW-1:0] dst_w, src_w, rd_addr;
	logic [CW-1:0] cnt_w;
	logic [15:0]   wtext;
	logic [11:0]   wcol;

	assign dst_w = IW'(14'(in_dst) % 14'(tccs_pkg::CELL_TOTAL));
	assign src_w = IW'(14'(in_src) % 14'(tccs_pkg::CELL_TOTAL));
	assign cnt_w = (in_cnt > 14'(tccs_pkg::CELL_TOTAL)) ? CW'(tccs_pkg::CELL_TOTAL)
		: CW'(in_cnt);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= tccs_pkg::op_t'(in_op);
			char_q <= in_char;
			attr_q <= in_attr;
			col_q  <= {in_bg, in_fg};
			desc_q <= (src_w < dst_w);
			if (tccs_pkg::op_t'(in_op) == tccs_pkg::OP_INVERT) begin
				dst_q <= '0;
				src_q <= '0;
				cnt_q <= CW'(tccs_pkg::CELL_TOTAL);
			end else if (tccs_pkg::op_t'(in_op) == tccs_pkg::OP_MOVE && src_w < dst_w
					&& cnt_w != '0) begin
				dst_q <= IW'((CW'(dst_w) + cnt_w - 1'b1) % CW'(tccs_pkg::CELL_TOTAL));
				src_q <= IW'((CW'(src_w) + cnt_w - 1'b1) % CW'(tccs_pkg::CELL_TOTAL));
				cnt_q <= cnt_w;
			end else begin
				dst_q <= dst_w;
				src_q <= src_w;
				cnt_q <= (tccs_pkg::op_t'(in_op) == tccs_pkg::OP_MOVE && src_w == dst_w)
					? '0 : cnt_w;
			end
		end else if (cmd.step) begin
			cnt_q <= cnt_q - 1'b1;
			if (desc_q && op_q == tccs_pkg::OP_MOVE) begin
				dst_q <= (dst_q == '0) ? IW'(tccs_pkg::CELL_TOTAL - 1) : dst_q - 1'b1;
				src_q <= (src_q == '0) ? IW'(tccs_pkg::CELL_TOTAL - 1) : src_q - 1'b1;
			end else begin
				dst_q <= (dst_q == IW'(tccs_pkg::CELL_TOTAL - 1)) ? '0 : dst_q + 1'b1;
				src_q <= (src_q == IW'(tccs_pkg::CELL_TOTAL - 1)) ? '0 : src_q + 1'b1;
			end
		end
	end

	assign rd_addr = (op_q == tccs_pkg::OP_MOVE) ? src_q : dst_q;

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rtext_q <= text_mem[rd_addr];
			rcol_q  <= color_mem[rd_addr];
		end
	end

	always_comb begin
		wtext = {attr_q, char_q};
		wcol  = col_q;
		case (op_q)
			tccs_pkg::OP_WCHAR: begin
				wtext = {rtext_q[15:8], char_q};
				wcol  = rcol_q;
			end
			tccs_pkg::OP_WATTR: begin
				wtext = {attr_q, rtext_q[7:0]};
				wcol  = rcol_q;
			end
			tccs_pkg::OP_WCOLOR: begin
				wtext = rtext_q;
			end
			tccs_pkg::OP_MOVE: begin
				wtext = rtext_q;
				wcol  = rcol_q;
			end
			tccs_pkg::OP_INVERT: begin
				wtext = rtext_q;
				wcol  = {rcol_q[5:0], rcol_q[11:6]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			text_mem[dst_q]  <= wtext;
			color_mem[dst_q] <= wcol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (cmd.res_load) begin
			res_q <= (op_q == tccs_pkg::OP_READ) ? {rcol_q, rtext_q} : '0;
		end
	end

	assign res          = res_q;
	assign sts.op       = op_q;
	assign sts.single   = (op_q != tccs_pkg::OP_FILL) && (op_q != tccs_pkg::OP_MOVE)
		&& (op_q != tccs_pkg::OP_INVERT);
	assign sts.run_zero = (cnt_q == '0);
	assign sts.run_last = (cnt_q == CW'(1));

endmodule

// ----- rtl/tccs_ctrl.sv -----
// Controller state machine sequencing single-cell and run operations.
module tccs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  tccs_pkg::sts_t sts,
	output tccs_pkg::cmd_t cmd
);

	tccs_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic fin;
	logic in_go;

	assign in_go = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tccs_pkg::ST_IDLE:   if (in_go) state_d = tccs_pkg::ST_RMW;
			tccs_pkg::ST_RMW: begin
				if (sts.single) state_d = tccs_pkg::ST_OUT;
				else if (sts.run_zero) state_d = tccs_pkg::ST_OUT;
				else state_d = tccs_pkg::ST_RUN_RD;
			end
			tccs_pkg::ST_RUN_RD: state_d = tccs_pkg::ST_RUN_WR;
			tccs_pkg::ST_RUN_WR: state_d = sts.run_last ? tccs_pkg::ST_OUT
				: tccs_pkg::ST_RUN_RD;
			tccs_pkg::ST_OUT:    if (fin) state_d = tccs_pkg::ST_IDLE;
			default:             state_d = tccs_pkg::ST_IDLE;
		endcase
	end

	assign fin = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			tccs_pkg::ST_IDLE:   cmd.load = in_go;
			tccs_pkg::ST_RMW:    cmd.rd = 1'b1;
			tccs_pkg::ST_RUN_RD: cmd.rd = 1'b1;
			tccs_pkg::ST_RUN_WR: begin
				cmd.wr   = 1'b1;
				cmd.step = 1'b1;
			end
			tccs_pkg::ST_OUT: begin
				cmd.wr       = fin && sts.single && (sts.op != tccs_pkg::OP_READ);
				cmd.res_load = fin;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tccs_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tccs_pkg::ST_OUT && fin) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == tccs_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- rtl/text_cell_color_store.sv -----
// Top level of the text cell color store.
// A single-cell opcode occupies the block through accept, memory read,
// then merge and write; its result is loaded with that write, which waits
// while an earlier result is untaken. Fill, move and invert read and then
// write each of their N cells in turn through the one memory port; invert
// covers all cells. The result register lets the next item be taken while
// a result waits; a second result then holds the input until the first is
// taken. Cells read before ever written return undefined data.
module text_cell_color_store (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// opcode[2:0], cell_index[15:3], source_index[28:16], cell_count[42:29],
	// char_code[50:43], attr_bits[58:51], fg_color[64:59], bg_color[70:65]
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_char[7:0], read_attr[15:8], read_fg[21:16], read_bg[27:22]
	output logic [31:0] m_axis_tdata
);

	tccs_pkg::cmd_t cmd;
	tccs_pkg::sts_t sts;
	logic [27:0]    res;

	tccs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tccs_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.in_op   (s_axis_tdata[2:0]),
		.in_dst  (s_axis_tdata[15:3]),
		.in_src  (s_axis_tdata[28:16]),
		.in_cnt  (s_axis_tdata[42:29]),
		.in_char (s_axis_tdata[50:43]),
		.in_attr (s_axis_tdata[58:51]),
		.in_fg   (s_axis_tdata[64:59]),
		.in_bg   (s_axis_tdata[70:65]),
		.res     (res)
	);

	assign m_axis_tdata = {4'b0, res};

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the text cell color store.
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned CELL_TOTAL = tccs_pkg::CELL_TOTAL;

	typedef struct {
		tccs_pkg::op_t op;
		logic [12:0]   dst;
		logic [12:0]   src;
		logic [13:0]   cnt;
		logic [7:0]    ch;
		logic [7:0]    at;
		logic [5:0]    fg;
		logic [5:0]    bg;
		int            gap;
	} cmd_item_t;

	typedef struct {
		logic [7:0] ch;
		logic [7:0] at;
		logic [5:0] fg;
		logic [5:0] bg;
	} cell_view_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;

	text_cell_color_store i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	cmd_item_t   cmd_q[$];
	cell_view_t  view_q[$];
	logic [15:0] text_mem[CELL_TOTAL];
	logic [11:0] color_mem[CELL_TOTAL];
	int          n_total;
	int          n_accepted;
	int          n_results;
	int          n_errors;
	int          n_reads;
	int          n_runs;
	int          n_inverts;
	logic [12:0] hot_idx;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic void push_cmd(tccs_pkg::op_t op, int dst, int src, int cnt, int ch,
			int at, int fg, int bg, int gap);
		cmd_item_t c;
		c.op  = op;
		c.dst = dst[12:0];
		c.src = src[12:0];
		c.cnt = cnt[13:0];
		c.ch  = ch[7:0];
		c.at  = at[7:0];
		c.fg  = fg[5:0];
		c.bg  = bg[5:0];
		c.gap = gap;
		cmd_q.push_back(c);
	endfunction

	function automatic void predict_cell_op(cmd_item_t c);
		cell_view_t v;
		int         n;
		int         d;
		int         s;
		logic [11:0] col;
		v   = '{default: '0};
		n   = (c.cnt > CELL_TOTAL) ? CELL_TOTAL : c.cnt;
		d   = c.dst;
		s   = c.src;
		col = {c.bg, c.fg};
		case (c.op)
			tccs_pkg::OP_READ: begin
				v.ch = text_mem[d][7:0];
				v.at = text_mem[d][15:8];
				v.fg = color_mem[d][5:0];
				v.bg = color_mem[d][11:6];
				n_reads++;
			end
			tccs_pkg::OP_WCHAR:  text_mem[d][7:0] = c.ch;
			tccs_pkg::OP_WATTR:  text_mem[d][15:8] = c.at;
			tccs_pkg::OP_WCOLOR: color_mem[d] = col;
			tccs_pkg::OP_WCELL: begin
				text_mem[d]  = {c.at, c.ch};
				color_mem[d] = col;
			end
			tccs_pkg::OP_FILL: begin
				for (int i = 0; i < n; i++) begin
					text_mem[(d + i) % CELL_TOTAL]  = {c.at, c.ch};
					color_mem[(d + i) % CELL_TOTAL] = col;
				end
				n_runs++;
			end
			tccs_pkg::OP_MOVE: begin
				if (s > d) begin
					for (int i = 0; i < n; i++) begin
						text_mem[(d + i) % CELL_TOTAL]  = text_mem[(s + i) % CELL_TOTAL];
						color_mem[(d + i) % CELL_TOTAL] = color_mem[(s + i) % CELL_TOTAL];
					end
				end else if (s < d) begin
					for (int i = n - 1; i >= 0; i--) begin
						text_mem[(d + i) % CELL_TOTAL]  = text_mem[(s + i) % CELL_TOTAL];
						color_mem[(d + i) % CELL_TOTAL] = color_mem[(s + i) % CELL_TOTAL];
					end
				end
				n_runs++;
			end
			default: begin
				for (int i = 0; i < CELL_TOTAL; i++)
					color_mem[i] = {color_mem[i][5:0], color_mem[i][11:6]};
				n_inverts++;
			end
		endcase
		view_q.push_back(v);
	endfunction

	// Sender: one item in flight, gap drawn per item before it is offered.
	cmd_item_t cur_cmd;
	logic      offering;
	int        gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			offering = 1'b0;
			gap_left = -1;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_cell_op(cur_cmd);
				n_accepted++;
				offering = 1'b0;
				gap_left = -1;
			end
			if (!offering && cmd_q.size() > 0) begin
				if (gap_left < 0)
					gap_left = cmd_q[0].gap;
				if (gap_left == 0) begin
					cur_cmd  = cmd_q.pop_front();
					offering = 1'b1;
				end else begin
					gap_left--;
				end
			end
			s_axis_tvalid <= offering;
			s_axis_tdata  <= {1'b0, cur_cmd.bg, cur_cmd.fg, cur_cmd.at, cur_cmd.ch,
				cur_cmd.cnt, cur_cmd.src, cur_cmd.dst, cur_cmd.op};
		end
	end

	// Receiver: per-result stall, one long hold-off, and a stretch with none.
	int  stall_left;
	bit  long_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left = 3;
			long_done  = 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				cell_view_t v;
				n_results++;
				if (view_q.size() == 0) begin
					$error("result with nothing expected: %h", m_axis_tdata);
					n_errors++;
				end else begin
					v = view_q.pop_front();
					if (m_axis_tdata[7:0] !== v.ch) begin
						$error("read_char: expected %h, got %h", v.ch, m_axis_tdata[7:0]);
						n_errors++;
					end
					if (m_axis_tdata[15:8] !== v.at) begin
						$error("read_attr: expected %h, got %h", v.at, m_axis_tdata[15:8]);
						n_errors++;
					end
					if (m_axis_tdata[21:16] !== v.fg) begin
						$error("read_fg: expected %h, got %h", v.fg, m_axis_tdata[21:16]);
						n_errors++;
					end
					if (m_axis_tdata[27:22] !== v.bg) begin
						$error("read_bg: expected %h, got %h", v.bg, m_axis_tdata[27:22]);
						n_errors++;
					end
				end
				if (!long_done && n_results == 300) begin
					stall_left = 400;
					long_done  = 1'b1;
				end else if (n_results >= 500 && n_results < 600) begin
					stall_left = 0;
				end else begin
					stall_left = $urandom_range(0, 17);
				end
			end else if (stall_left > 0) begin
				stall_left--;
			end
			m_axis_tready <= (stall_left == 0);
		end
	end

	function automatic int draw_gap(int k);
		if (k >= 200 && k < 300)
			return 0;
		return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
	endfunction

	function automatic int draw_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 0;
		if (r < 10)
			return $urandom_range(8192, 16383);
		return $urandom_range(1, 40);
	endfunction

	initial begin
		int r;
		int big_runs;
		int inv_left;
		int d;
		arst_n     = 1'b0;
		n_accepted = 0;
		n_results  = 0;
		n_errors   = 0;
		n_reads    = 0;
		n_runs     = 0;
		n_inverts  = 0;
		for (int i = 0; i < CELL_TOTAL; i++) begin
			text_mem[i]  = '0;
			color_mem[i] = '0;
		end

		// Saturating fill covers the whole store so that every later read is defined.
		push_cmd(tccs_pkg::OP_FILL, 0, 8191, 16383, 8'h5a, 8'ha5, 6'h15, 6'h2a, 0);
		push_cmd(tccs_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
		push_cmd(tccs_pkg::OP_READ, 8191, 0, 0, 0, 0, 0, 0, 0);
		push_cmd(tccs_pkg::OP_WCELL, 8191, 0, 0, 8'hff, 8'hff, 6'h3f, 6'h00, 0);
		push_cmd(tccs_pkg::OP_READ, 8191, 0, 0, 0, 0, 0, 0, 0);
		push_cmd(tccs_pkg::OP_WCHAR, 8191, 8191, 16383, 8'h00, 8'hff, 6'h3f, 6'h3f, 0);
		push_cmd(tccs_pkg::OP_WATTR, 8191, 0, 0, 8'hff, 8'h00, 0, 0, 0);
		push_cmd(tccs_pkg::OP_WCOLOR, 8191, 0, 0, 0, 0, 6'h00, 6'h3f, 0);
		push_cmd(tccs_pkg::OP_READ, 8191, 0, 0, 0, 0, 0, 0, 0);
		push_cmd(tccs_pkg::OP_FILL, 8190, 0, 5, 8'h11, 8'h22, 6'h01, 6'h02, 0);
		push_cmd(tccs_pkg::OP_READ, 8190, 0, 0, 0, 0, 0, 0, 0);
		push_cmd(tccs_pkg::OP_READ, 2, 0, 0, 0, 0, 0, 0, 0);
		push_cmd(tccs_pkg::OP_FILL, 100, 0, 0, 8'h77, 8'h77, 6'h07, 6'h07, 0);
		push_cmd(tccs_pkg::OP_MOVE, 8190, 8188, 6, 0, 0, 0, 0, 0);
		push_cmd(tccs_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0, 0);
		push_cmd(tccs_pkg::OP_MOVE, 8188, 8190, 6, 0, 0, 0, 0, 0);
		push_cmd(tccs_pkg::OP_READ, 8189, 0, 0, 0, 0, 0, 0, 0);
		push_cmd(tccs_pkg::OP_MOVE, 50, 50, 10, 0, 0, 0, 0, 0);
		push_cmd(tccs_pkg::OP_MOVE, 60, 0, 0, 0, 0, 0, 0, 0);
		push_cmd(tccs_pkg::OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0);
		push_cmd(tccs_pkg::OP_READ, 8191, 0, 0, 0, 0, 0, 0, 0);
		push_cmd(tccs_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);

		big_runs = 0;
		inv_left = 10;
		hot_idx  = 13'd0;
		for (int k = 0; k < 830; k++) begin
			r = $urandom_range(0, 199);
			d = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 8191)
				: (hot_idx + $urandom_range(0, 40)) % CELL_TOTAL;
			if (r < 70) begin
				push_cmd(tccs_pkg::OP_READ, d, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, draw_gap(k));
			end else if (r < 150) begin
				tccs_pkg::op_t op;
				op = tccs_pkg::op_t'(1 + (r - 70) / 20);
				hot_idx = 13'(d);
				push_cmd(op, d, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, draw_gap(k));
			end else if (r < 197 || inv_left == 0) begin
				int c;
				int s;
				c = draw_count();
				if (c >= 8192) begin
					if (big_runs >= 10)
						c = $urandom_range(1, 40);
					else
						big_runs++;
				end
				d = $urandom_range(0, 8191);
				s = ($urandom_range(0, 3) == 0) ? d
					: (d + CELL_TOTAL + $urandom_range(0, 60) - 30) % CELL_TOTAL;
				if ($urandom_range(0, 4) == 0)
					s = $urandom_range(0, 8191);
				hot_idx = 13'(d);
				push_cmd((r % 2 == 0) ? tccs_pkg::OP_FILL : tccs_pkg::OP_MOVE, d, s, c,
					$urandom, $urandom, $urandom, $urandom, draw_gap(k));
			end else begin
				inv_left--;
				push_cmd(tccs_pkg::OP_INVERT, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, draw_gap(k));
			end
		end
		n_total = cmd_q.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		wait (n_accepted == n_total && view_q.size() == 0);
		repeat (50) @(posedge clk);
		$display("Ran %0d items: %0d reads checked, %0d fills and moves, %0d inverts.",
			n_accepted, n_reads, n_runs, n_inverts);
		$display("Results seen: %0d, mismatches: %0d.", n_results, n_errors);
		if (n_errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#(12 * 3000000);
		$display("Timeout with %0d of %0d items sent.", n_accepted, n_total);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/tccs_pkg.sv
rtl/tccs_datapath.sv
rtl/tccs_ctrl.sv
rtl/text_cell_color_store.sv
tb/sv/tb_top.sv
